[src/video_unit_register_interface_defines.svh]
// Assertion macros for the video unit register interface.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef VIDEO_UNIT_REGISTER_INTERFACE_DEFINES_SVH
`define VIDEO_UNIT_REGISTER_INTERFACE_DEFINES_SVH

`ifndef SYNTH
// check outside reset
`define VURI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
// check that also holds while reset is applied
`define VURI_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);
`else
`define VURI_ASSERT(lbl, prop, msg)
`define VURI_ASSERT_RST(lbl, prop, msg)
`endif

`endif

[src/vuri_pkg.sv]
// Shared types and constants of the video unit register interface.
// No dependencies; imported by the top level, vuri_core, vuri_out and the testbench.
`default_nettype none

package vuri_pkg;

    // item kinds
    typedef enum logic [1:0] {
        OP_READ  = 2'd0,
        OP_WRITE = 2'd1,
        OP_EVENT = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    // register window
    localparam logic [2:0] REG_CTRL_A   = 3'd0;
    localparam logic [2:0] REG_CTRL_B   = 3'd1;
    localparam logic [2:0] REG_STATUS   = 3'd2;
    localparam logic [2:0] REG_OAM_ADDR = 3'd3;
    localparam logic [2:0] REG_OAM_DATA = 3'd4;
    localparam logic [2:0] REG_SCROLL   = 3'd5;
    localparam logic [2:0] REG_ADDR     = 3'd6;
    localparam logic [2:0] REG_DATA     = 3'd7;

    // memory sizes
    localparam int VIDEO_MEM_DEPTH_DEF = 16384;
    localparam int SPRITE_MEM_DEPTH    = 256;
    localparam int SPRITE_AW           = $clog2(SPRITE_MEM_DEPTH);
    localparam int PALETTE_DEPTH       = 32;
    localparam int PAL_AW              = $clog2(PALETTE_DEPTH);
    localparam int PAL_MIRRORS         = PALETTE_DEPTH / 4;

    // frame and address constants
    localparam logic [16:0] LAST_FRAME_CYCLE = 17'd89341;
    localparam logic [14:0] PALETTE_BASE     = 15'h3F00;
    localparam logic [5:0]  PALETTE_PAGE     = 6'h3F;
    localparam logic [14:0] ADDR_INC_ROW     = 15'd32;
    localparam logic [14:0] ADDR_INC_COL     = 15'd1;

    // memory port control
    typedef struct packed {
        logic we;
        logic re;
    } t_mem_ctl;

    // one result beat
    typedef struct packed {
        logic        write_toggle;
        logic [7:0]  control_b;
        logic [7:0]  control_a;
        logic [2:0]  fine_x;
        logic [14:0] temp_addr;
        logic [14:0] vram_addr;
        logic        a12_rise;
        logic        vblank_suppressed;
        logic        nmi_enable;
        logic [7:0]  read_data;
    } t_result;

endpackage

`default_nettype wire

[src/video_unit_register_interface.sv]
// Top level of the video unit register interface: register core, video and
// sprite RAMs, result queue. Depends on vuri_pkg, vuri_core, vuri_ram, vuri_out.
//
//  Channel   Direction  Beat contents
//  s_axis    in         tuser: opcode; tdata: reg_index, wdata, frame_cycle
//  m_axis    out        tdata: read_data, flags, addresses, scroll, controls
//
//  One beat is accepted per cycle while s_axis_tready is high; each result
//  passes the staging slot, which waits for sprite RAM read data, and then
//  the output register behind it.
//  Register state updates in the accept cycle, so back-to-back beats need no
//  interlock. Two results can wait while m_axis stalls before s_axis_tready
//  drops. Synchronous active-low reset clears all control state; RAM and
//  palette contents are not cleared.
`default_nettype none

module video_unit_register_interface
    import vuri_pkg::*;
#(
    parameter int VIDEO_MEM_DEPTH = VIDEO_MEM_DEPTH_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [2:0] reg_index, [10:3] wdata, [27:11] frame_cycle, [31:28] zero
    input  wire logic [31:0] s_axis_tdata,
    // [1:0] opcode
    input  wire logic [1:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [7:0] read_data, [8] nmi_enable, [9] vblank_suppressed, [10] a12_rise,
    // [25:11] vram_addr, [40:26] temp_addr, [43:41] fine_x, [51:44] control_a,
    // [59:52] control_b, [60] write_toggle, [63:61] zero
    output logic      [63:0] m_axis_tdata
);

    localparam int VAW = $clog2(VIDEO_MEM_DEPTH);

    logic                 acc;
    logic                 in_ready;
    t_mem_ctl             vram_ctl;
    logic [VAW-1:0]       vram_addr;
    logic [7:0]           vram_wdata;
    logic [7:0]           vram_q;
    t_mem_ctl             oam_ctl;
    logic [SPRITE_AW-1:0] oam_addr;
    logic [7:0]           oam_wdata;
    logic [7:0]           oam_q;
    t_result              result;
    logic                 use_oam;

    assign acc           = s_axis_tvalid && in_ready;
    assign s_axis_tready = in_ready;

    // register state and memory requests
    vuri_core #(
        .VIDEO_MEM_DEPTH(VIDEO_MEM_DEPTH)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_acc        (acc),
        .i_opcode     (t_opcode'(s_axis_tuser)),
        .i_reg_index  (s_axis_tdata[2:0]),
        .i_wdata      (s_axis_tdata[10:3]),
        .i_frame_cycle(s_axis_tdata[27:11]),
        .i_vram_q     (vram_q),
        .o_vram_ctl   (vram_ctl),
        .o_vram_addr  (vram_addr),
        .o_vram_wdata (vram_wdata),
        .o_oam_ctl    (oam_ctl),
        .o_oam_addr   (oam_addr),
        .o_oam_wdata  (oam_wdata),
        .o_result     (result),
        .o_use_oam    (use_oam)
    );

    // flat video memory
    vuri_ram #(
        .DEPTH(VIDEO_MEM_DEPTH),
        .WIDTH(8)
    ) u_vram (
        .i_clk  (i_clk),
        .i_we   (vram_ctl.we),
        .i_waddr(vram_addr),
        .i_wdata(vram_wdata),
        .i_re   (vram_ctl.re),
        .i_raddr(vram_addr),
        .o_rdata(vram_q)
    );

    // sprite memory
    vuri_ram #(
        .DEPTH(SPRITE_MEM_DEPTH),
        .WIDTH(8)
    ) u_oam (
        .i_clk  (i_clk),
        .i_we   (oam_ctl.we),
        .i_waddr(oam_addr),
        .i_wdata(oam_wdata),
        .i_re   (oam_ctl.re),
        .i_raddr(oam_addr),
        .o_rdata(oam_q)
    );

    // result queue
    vuri_out u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_acc     (acc),
        .i_result  (result),
        .i_use_oam (use_oam),
        .i_oam_q   (oam_q),
        .i_m_tready(m_axis_tready),
        .o_in_ready(in_ready),
        .o_m_tvalid(m_axis_tvalid),
        .o_m_tdata (m_axis_tdata)
    );

endmodule

`default_nettype wire

[src/vuri_ram.sv]
// Simple dual-port synchronous RAM: one write port, one read port,
// registered read data that holds while no read is issued. Uses no package.
`default_nettype none

module vuri_ram #(
    parameter  int DEPTH = 256,
    parameter  int WIDTH = 8,
    localparam int AW    = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // read port, registered
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

[src/vuri_core.sv]
// Register state, palette and memory request logic of the register interface.
// Depends on vuri_pkg and the assertion macro header.
`default_nettype none
`include "video_unit_register_interface_defines.svh"

module vuri_core
    import vuri_pkg::*;
#(
    parameter  int VIDEO_MEM_DEPTH = VIDEO_MEM_DEPTH_DEF,
    localparam int VAW             = $clog2(VIDEO_MEM_DEPTH)
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_acc,
    input  wire t_opcode              i_opcode,
    input  wire logic [2:0]           i_reg_index,
    input  wire logic [7:0]           i_wdata,
    input  wire logic [16:0]          i_frame_cycle,
    input  wire logic [7:0]           i_vram_q,
    output t_mem_ctl                  o_vram_ctl,
    output logic      [VAW-1:0]       o_vram_addr,
    output logic      [7:0]           o_vram_wdata,
    output t_mem_ctl                  o_oam_ctl,
    output logic      [SPRITE_AW-1:0] o_oam_addr,
    output logic      [7:0]           o_oam_wdata,
    output t_result                   o_result,
    output logic                      o_use_oam
);

    localparam logic [15:0] DEPTH1 = 16'(VIDEO_MEM_DEPTH);
    localparam logic [15:0] DEPTH2 = 16'(2 * VIDEO_MEM_DEPTH);

    logic [7:0]  r_ctrl_a, n_ctrl_a;
    logic [7:0]  r_ctrl_b, n_ctrl_b;
    logic [2:0]  r_status, n_status;
    logic        r_nmi, n_nmi;
    logic        r_sup, n_sup;
    logic [7:0]  r_rbuf, n_rbuf;
    logic        r_fetch_vld, n_fetch_vld;
    logic [14:0] r_addr, n_addr;
    logic [14:0] r_temp, n_temp;
    logic [2:0]  r_fine, n_fine;
    logic        r_toggle, n_toggle;
    logic [7:0]  r_oam_addr, n_oam_addr;
    logic        r_lb12_rd, n_lb12_rd;
    logic        r_lb12_wr, n_lb12_wr;
    logic [7:0]  r_pal [PALETTE_DEPTH];

    logic [14:0] addr_inc;
    logic [14:0] addr_sum;
    logic [15:0] vmod0, vmod1, vmod2;
    logic [7:0]  fetch_eff;
    logic [7:0]  rdata;
    logic        rise;
    logic        pal_we_all;
    logic        pal_we_one;
    logic        use_oam;
    t_mem_ctl    vram_ctl;
    t_mem_ctl    oam_ctl;

    // address step and video memory index (address is below four depths)
    assign addr_inc = r_ctrl_a[2] ? ADDR_INC_ROW : ADDR_INC_COL;
    assign addr_sum = r_addr + addr_inc;
    assign vmod0    = {2'b00, r_addr[13:0]};
    assign vmod1    = (vmod0 >= DEPTH2) ? (vmod0 - DEPTH2) : vmod0;
    assign vmod2    = (vmod1 >= DEPTH1) ? (vmod1 - DEPTH1) : vmod1;

    // fetch latch lives in the video RAM read register once loaded
    assign fetch_eff = r_fetch_vld ? i_vram_q : 8'h00;

    // next state for the item on the input
    always_comb begin
        n_ctrl_a    = r_ctrl_a;
        n_ctrl_b    = r_ctrl_b;
        n_status    = r_status;
        n_nmi       = r_nmi;
        n_sup       = r_sup;
        n_rbuf      = r_rbuf;
        n_fetch_vld = r_fetch_vld;
        n_addr      = r_addr;
        n_temp      = r_temp;
        n_fine      = r_fine;
        n_toggle    = r_toggle;
        n_oam_addr  = r_oam_addr;
        n_lb12_rd   = r_lb12_rd;
        n_lb12_wr   = r_lb12_wr;
        rdata       = 8'h00;
        rise        = 1'b0;
        pal_we_all  = 1'b0;
        pal_we_one  = 1'b0;
        use_oam     = 1'b0;
        vram_ctl    = '0;
        oam_ctl     = '0;
        unique case (i_opcode)
            OP_READ: begin
                unique case (i_reg_index)
                    REG_STATUS: begin
                        if (i_frame_cycle == LAST_FRAME_CYCLE) begin
                            n_sup = 1'b1;
                            n_nmi = 1'b0;
                        end
                        if (i_frame_cycle == 17'd0 || i_frame_cycle == 17'd1) begin
                            n_nmi = 1'b0;
                        end
                        rdata = {r_status, r_rbuf[4:0]};
                        if (r_status[2]) begin
                            n_status = {1'b0, r_status[1:0]};
                        end
                        n_toggle = 1'b0;
                    end
                    REG_OAM_DATA: begin
                        oam_ctl.re = 1'b1;
                        use_oam    = 1'b1;
                    end
                    REG_DATA: begin
                        rise        = !r_lb12_rd && r_addr[12];
                        n_lb12_rd   = r_addr[12];
                        vram_ctl.re = 1'b1;
                        n_fetch_vld = 1'b1;
                        if (r_addr[13:8] == PALETTE_PAGE) begin
                            n_rbuf = r_pal[r_addr[PAL_AW-1:0]];
                        end else begin
                            n_rbuf = fetch_eff;
                        end
                        rdata  = n_rbuf;
                        n_addr = {1'b0, r_addr[13:0]} + addr_inc;
                    end
                    default: begin
                        rdata = r_rbuf;
                    end
                endcase
            end
            OP_WRITE: begin
                unique case (i_reg_index)
                    REG_CTRL_A: begin
                        n_ctrl_a = i_wdata;
                        n_nmi    = i_wdata[7];
                        n_temp   = {r_temp[14:12], i_wdata[1:0], r_temp[9:0]};
                    end
                    REG_CTRL_B: begin
                        n_ctrl_b = i_wdata;
                    end
                    REG_OAM_ADDR: begin
                        n_oam_addr = i_wdata;
                    end
                    REG_OAM_DATA: begin
                        oam_ctl.we = 1'b1;
                        n_oam_addr = r_oam_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_temp   = {r_temp[14:5], i_wdata[7:3]};
                            n_fine   = i_wdata[2:0];
                            n_toggle = 1'b1;
                        end else begin
                            n_temp   = {i_wdata[2:0], r_temp[11:10], i_wdata[7:3],
                                        r_temp[4:0]};
                            n_toggle = 1'b0;
                        end
                    end
                    REG_ADDR: begin
                        if (!r_toggle) begin
                            n_temp   = {1'b0, i_wdata[5:0], r_temp[7:0]};
                            n_toggle = 1'b1;
                        end else begin
                            n_temp   = {r_temp[14:8], i_wdata};
                            n_addr   = n_temp;
                            n_toggle = 1'b0;
                        end
                    end
                    REG_DATA: begin
                        rise      = !r_lb12_wr && r_addr[12];
                        n_lb12_wr = r_addr[12];
                        if (r_addr < PALETTE_BASE) begin
                            vram_ctl.we = 1'b1;
                        end else if (r_addr[3:0] == 4'h0) begin
                            pal_we_all = 1'b1;
                        end else if (r_addr[1:0] != 2'b00) begin
                            pal_we_one = 1'b1;
                        end
                        n_addr = {1'b0, addr_sum[13:0]};
                    end
                    default: begin
                        // status register ignores writes
                    end
                endcase
            end
            OP_EVENT: begin
                n_status = i_wdata[7:5];
                n_sup    = 1'b0;
            end
            OP_NONE: begin
            end
        endcase
    end

    // control and register state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_a    <= '0;
            r_ctrl_b    <= '0;
            r_status    <= '0;
            r_nmi       <= 1'b0;
            r_sup       <= 1'b0;
            r_rbuf      <= '0;
            r_fetch_vld <= 1'b0;
            r_addr      <= '0;
            r_temp      <= '0;
            r_fine      <= '0;
            r_toggle    <= 1'b0;
            r_oam_addr  <= '0;
            r_lb12_rd   <= 1'b0;
            r_lb12_wr   <= 1'b0;
        end else if (i_acc) begin
            r_ctrl_a    <= n_ctrl_a;
            r_ctrl_b    <= n_ctrl_b;
            r_status    <= n_status;
            r_nmi       <= n_nmi;
            r_sup       <= n_sup;
            r_rbuf      <= n_rbuf;
            r_fetch_vld <= n_fetch_vld;
            r_addr      <= n_addr;
            r_temp      <= n_temp;
            r_fine      <= n_fine;
            r_toggle    <= n_toggle;
            r_oam_addr  <= n_oam_addr;
            r_lb12_rd   <= n_lb12_rd;
            r_lb12_wr   <= n_lb12_wr;
        end
    end

    // palette: entry-0 writes hit every fourth entry
    always_ff @(posedge i_clk) begin
        if (i_acc && pal_we_all) begin
            for (int i = 0; i < PAL_MIRRORS; i++) begin
                r_pal[PAL_AW'(i * 4)] <= i_wdata;
            end
        end else if (i_acc && pal_we_one) begin
            r_pal[r_addr[PAL_AW-1:0]] <= i_wdata;
        end
    end

    // memory requests
    assign o_vram_ctl   = '{we: vram_ctl.we && i_acc, re: vram_ctl.re && i_acc};
    assign o_vram_addr  = vmod2[VAW-1:0];
    assign o_vram_wdata = i_wdata;
    assign o_oam_ctl    = '{we: oam_ctl.we && i_acc, re: oam_ctl.re && i_acc};
    assign o_oam_addr   = r_oam_addr[SPRITE_AW-1:0];
    assign o_oam_wdata  = i_wdata;

    // result of this item, register fields after the step
    assign o_result = '{
        write_toggle:      n_toggle,
        control_b:         n_ctrl_b,
        control_a:         n_ctrl_a,
        fine_x:            n_fine,
        temp_addr:         n_temp,
        vram_addr:         n_addr,
        a12_rise:          rise,
        vblank_suppressed: n_sup,
        nmi_enable:        n_nmi,
        read_data:         rdata
    };
    assign o_use_oam = use_oam;

    // checks
    `VURI_ASSERT(a_data_wr_clears_b14, i_acc && i_opcode == OP_WRITE && i_reg_index == REG_DATA |=> !r_addr[14], "data write left address bit 14 set")
    `VURI_ASSERT(a_status_rd_toggle, i_acc && i_opcode == OP_READ && i_reg_index == REG_STATUS |=> !r_toggle, "status read did not reset toggle")
    `VURI_ASSERT(a_event_clears_sup, i_acc && i_opcode == OP_EVENT |=> !r_sup, "status event left suppression set")
    `VURI_ASSERT(a_ctrl_nmi, i_acc && i_opcode == OP_WRITE && i_reg_index == REG_CTRL_A |=> r_nmi == r_ctrl_a[7], "NMI flag differs from control bit 7")
    `VURI_ASSERT_RST(a_reset_clears, !i_rst_n |=> !r_sup && !r_toggle && !r_fetch_vld, "reset did not clear control state")

endmodule

`default_nettype wire

[src/vuri_out.sv]
// Two-entry result queue: a staging slot that waits for sprite RAM data,
// then the output register that drives the master beat. Depends on vuri_pkg.
`default_nettype none

module vuri_out
    import vuri_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_acc,
    input  wire t_result     i_result,
    input  wire logic        i_use_oam,
    input  wire logic [7:0]  i_oam_q,
    input  wire logic        i_m_tready,
    output logic             o_in_ready,
    output logic             o_m_tvalid,
    output logic      [63:0] o_m_tdata
);

    logic    r_s1_vld;
    logic    r_s1_oam;
    t_result r_s1;
    logic    r_out_vld;
    t_result r_out;
    t_result s1_final;
    logic    adv;

    // staging slot moves when the output register is free or drains
    assign adv        = !r_out_vld || i_m_tready;
    assign o_in_ready = !r_s1_vld || adv;

    // sprite read data comes from the RAM read register, which loads with the staging slot
    always_comb begin
        s1_final = r_s1;
        if (r_s1_oam) begin
            s1_final.read_data = i_oam_q;
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (i_acc) begin
                r_s1_vld <= 1'b1;
            end else if (adv) begin
                r_s1_vld <= 1'b0;
            end
            if (adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_acc) begin
            r_s1     <= i_result;
            r_s1_oam <= i_use_oam;
        end
        if (adv && r_s1_vld) begin
            r_out <= s1_final;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = {3'b000, r_out};

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for video_unit_register_interface: directed table, then
// random register traffic scored by a cycle-free predictor of the register file.
// Depends on vuri_pkg and the RTL of the block only.
`default_nettype none

module testbench;
    import vuri_pkg::*;

    localparam int CLK_HALF    = 6;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_BEATS = 510;

    // one row of the directed table
    typedef struct packed {
        t_opcode     op;
        logic [2:0]  ri;
        logic [7:0]  d;
        logic [16:0] fc;
        logic        has_fixed;
        t_result     fixed;
    } t_stim_row;

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        s_axis_tvalid  = 1'b0;
    logic        s_axis_tready;
    // [2:0] reg_index, [10:3] wdata, [27:11] frame_cycle, [31:28] zero
    logic [31:0] s_axis_tdata   = '0;
    // [1:0] opcode
    logic [1:0]  s_axis_tuser   = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready  = 1'b0;
    // [7:0] read_data, [8] nmi_enable, [9] vblank_suppressed, [10] a12_rise,
    // [25:11] vram_addr, [40:26] temp_addr, [43:41] fine_x, [51:44] control_a,
    // [59:52] control_b, [60] write_toggle, [63:61] zero
    logic [63:0] m_axis_tdata;

    // register file image kept by the predictor
    logic [7:0]  cur_ctrl_a    = '0;
    logic [7:0]  cur_ctrl_b    = '0;
    logic [2:0]  cur_status    = '0;
    logic        cur_nmi       = 1'b0;
    logic        cur_suppress  = 1'b0;
    logic [7:0]  cur_rd_buf    = '0;
    logic [7:0]  cur_fetch     = '0;
    logic [14:0] cur_vaddr     = '0;
    logic [14:0] cur_temp      = '0;
    logic [2:0]  cur_fine      = '0;
    logic        cur_toggle    = 1'b0;
    logic [7:0]  cur_oam_addr  = '0;
    logic        cur_bit12_rd  = 1'b0;
    logic        cur_bit12_wr  = 1'b0;
    logic [7:0]  oam_image     [SPRITE_MEM_DEPTH];
    logic [7:0]  palette_image [PALETTE_DEPTH];
    logic [7:0]  vram_image    [VIDEO_MEM_DEPTH_DEF];
    bit          oam_known     [SPRITE_MEM_DEPTH];
    bit          vram_known    [VIDEO_MEM_DEPTH_DEF];
    logic [13:0] vram_filled_list [$];
    logic [7:0]  oam_filled_list  [$];

    t_result     result_queue [$];
    t_stim_row   directed_rows [$];
    int          error_count    = 0;
    int          beats_sent     = 0;
    int          cycle_count    = 0;
    int          send_idle_pct  = 0;
    int          ready_idle_pct = 0;

    video_unit_register_interface dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // clock
    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // data port address increment: 1 across, 32 down
    function automatic void step_vaddr();
        cur_vaddr = cur_vaddr + (cur_ctrl_a[2] ? ADDR_INC_ROW : ADDR_INC_COL);
    endfunction

    // apply one accepted beat to the register image, return the result beat
    function automatic t_result predict_access(t_opcode op, logic [2:0] ri,
                                               logic [7:0] d, logic [16:0] fc);
        t_result r;
        logic [7:0] rd;
        logic rise;
        rd   = '0;
        rise = 1'b0;
        case (op)
            OP_READ: begin
                case (ri)
                    REG_STATUS: begin
                        if (fc == LAST_FRAME_CYCLE) begin
                            cur_suppress = 1'b1;
                            cur_nmi      = 1'b0;
                        end
                        if (fc == 17'd0 || fc == 17'd1) cur_nmi = 1'b0;
                        rd = {cur_status, cur_rd_buf[4:0]};
                        if (rd[7]) cur_status[2] = 1'b0;
                        cur_toggle = 1'b0;
                    end
                    REG_OAM_DATA: rd = oam_image[cur_oam_addr];
                    REG_DATA: begin
                        cur_rd_buf = cur_fetch;
                        cur_vaddr[14] = 1'b0;
                        if (!cur_bit12_rd && cur_vaddr[12]) rise = 1'b1;
                        cur_bit12_rd = cur_vaddr[12];
                        cur_fetch = vram_image[cur_vaddr[13:0]];
                        if (cur_vaddr[13:8] == PALETTE_PAGE)
                            cur_rd_buf = palette_image[cur_vaddr[4:0]];
                        step_vaddr();
                        rd = cur_rd_buf;
                    end
                    default: rd = cur_rd_buf;
                endcase
            end
            OP_WRITE: begin
                case (ri)
                    REG_CTRL_A: begin
                        cur_ctrl_a = d;
                        cur_nmi = d[7];
                        cur_temp[11:10] = d[1:0];
                    end
                    REG_CTRL_B: cur_ctrl_b = d;
                    REG_OAM_ADDR: cur_oam_addr = d;
                    REG_OAM_DATA: begin
                        oam_image[cur_oam_addr] = d;
                        if (!oam_known[cur_oam_addr]) oam_filled_list.push_back(cur_oam_addr);
                        oam_known[cur_oam_addr] = 1'b1;
                        cur_oam_addr = cur_oam_addr + 8'd1;
                    end
                    REG_SCROLL: begin
                        if (!cur_toggle) begin
                            cur_temp[4:0] = d[7:3];
                            cur_fine = d[2:0];
                        end else begin
                            cur_temp[9:5]   = d[7:3];
                            cur_temp[14:12] = d[2:0];
                        end
                        cur_toggle = ~cur_toggle;
                    end
                    REG_ADDR: begin
                        if (!cur_toggle) begin
                            cur_temp = {1'b0, d[5:0], cur_temp[7:0]};
                        end else begin
                            cur_temp = {cur_temp[14:8], d};
                            cur_vaddr = cur_temp;
                        end
                        cur_toggle = ~cur_toggle;
                    end
                    REG_DATA: begin
                        if (!cur_bit12_wr && cur_vaddr[12]) rise = 1'b1;
                        cur_bit12_wr = cur_vaddr[12];
                        if (cur_vaddr < PALETTE_BASE) begin
                            vram_image[cur_vaddr[13:0]] = d;
                            if (!vram_known[cur_vaddr[13:0]])
                                vram_filled_list.push_back(cur_vaddr[13:0]);
                            vram_known[cur_vaddr[13:0]] = 1'b1;
                        end else if (cur_vaddr[3:0] == 4'd0) begin
                            // entry 0 and its mirrors all take the byte
                            for (int i = 0; i < PAL_MIRRORS; i++) palette_image[i * 4] = d;
                        end else if (cur_vaddr[1:0] != 2'd0) begin
                            palette_image[cur_vaddr[4:0]] = d;
                        end
                        step_vaddr();
                        cur_vaddr[14] = 1'b0;
                    end
                    default: ;
                endcase
            end
            OP_EVENT: begin
                cur_status   = d[7:5];
                cur_suppress = 1'b0;
            end
            default: ;
        endcase
        r                   = '0;
        r.read_data         = rd;
        r.nmi_enable        = cur_nmi;
        r.vblank_suppressed = cur_suppress;
        r.a12_rise          = rise;
        r.vram_addr         = cur_vaddr;
        r.temp_addr         = cur_temp;
        r.fine_x            = cur_fine;
        r.control_a         = cur_ctrl_a;
        r.control_b         = cur_ctrl_b;
        r.write_toggle      = cur_toggle;
        return r;
    endfunction

    // result known by hand: no address, scroll or toggle activity yet
    function automatic t_result fixed_result(logic [7:0] rd, logic nmi, logic sup,
                                             logic [7:0] ca, logic [7:0] cb,
                                             logic [14:0] tmp);
        t_result r;
        r                   = '0;
        r.read_data         = rd;
        r.nmi_enable        = nmi;
        r.vblank_suppressed = sup;
        r.control_a         = ca;
        r.control_b         = cb;
        r.temp_addr         = tmp;
        return r;
    endfunction

    function automatic logic [16:0] any_frame();
        return 17'($urandom_range(LAST_FRAME_CYCLE));
    endfunction

    // status reads lean on the frame positions that matter
    function automatic logic [16:0] status_frame();
        case ($urandom_range(3))
            0:       return LAST_FRAME_CYCLE;
            1:       return 17'd0;
            2:       return 17'd1;
            default: return any_frame();
        endcase
    endfunction

    // data-port reads only where the fetched entry holds a written value
    function automatic bit data_read_ok();
        return vram_known[cur_vaddr[13:0]];
    endfunction

    function automatic logic [13:0] write_base();
        case ($urandom_range(9))
            0, 1, 2: return 14'(14'h0FE0 + $urandom_range(63));
            3:       return 14'(14'h1FE0 + $urandom_range(63));
            4:       return 14'(14'h3EE0 + $urandom_range(31));
            5, 6:    return 14'(PALETTE_BASE + $urandom_range(255));
            default: return 14'($urandom_range(16383));
        endcase
    endfunction

    // present one beat, wait for the handshake, then predict it
    task automatic drive_beat(input t_opcode op, input logic [2:0] ri,
                              input logic [7:0] d, input logic [16:0] fc,
                              input bit has_fixed = 1'b0, input t_result fixed = '0);
        t_result want;
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {4'd0, fc, d, ri};
        do @(posedge i_clk); while (!s_axis_tready);
        want = predict_access(op, ri, d, fc);
        result_queue.push_back(has_fixed ? fixed : want);
        if (!(op == OP_NONE || (op == OP_WRITE && ri == REG_STATUS))) beats_sent++;
    endtask

    task automatic clear_toggle();
        if (cur_toggle) drive_beat(OP_READ, REG_STATUS, 8'($urandom), status_frame());
    endtask

    task automatic load_address(input logic [13:0] a);
        clear_toggle();
        drive_beat(OP_WRITE, REG_ADDR, {2'($urandom), a[13:8]}, any_frame());
        drive_beat(OP_WRITE, REG_ADDR, a[7:0], any_frame());
    endtask

    // one random sequence: mostly well-formed accesses, some noise
    task automatic run_random_sequence();
        int kind;
        int n;
        logic [2:0] ri;
        logic [7:0] a;
        kind = $urandom_range(99);
        n    = $urandom_range(1, 8);
        if (kind < 22) begin
            load_address(write_base());
            repeat (n) drive_beat(OP_WRITE, REG_DATA, 8'($urandom), any_frame());
        end else if (kind < 42) begin
            if (vram_filled_list.size() != 0) begin
                load_address(vram_filled_list[$urandom_range(vram_filled_list.size() - 1)]);
                repeat (n)
                    if (data_read_ok())
                        drive_beat(OP_READ, REG_DATA, 8'($urandom), any_frame());
            end
        end else if (kind < 50) begin
            ri = $urandom_range(1) ? REG_CTRL_A : REG_CTRL_B;
            drive_beat(OP_WRITE, ri, 8'($urandom), any_frame());
        end else if (kind < 57) begin
            clear_toggle();
            drive_beat(OP_WRITE, REG_SCROLL, 8'($urandom), any_frame());
            drive_beat(OP_WRITE, REG_SCROLL, 8'($urandom), any_frame());
        end else if (kind < 65) begin
            a = $urandom_range(1) ? 8'($urandom_range(8'hF8, 8'hFF)) : 8'($urandom);
            drive_beat(OP_WRITE, REG_OAM_ADDR, a, any_frame());
            repeat (n) drive_beat(OP_WRITE, REG_OAM_DATA, 8'($urandom), any_frame());
        end else if (kind < 72) begin
            if (oam_filled_list.size() != 0) begin
                a = oam_filled_list[$urandom_range(oam_filled_list.size() - 1)];
                drive_beat(OP_WRITE, REG_OAM_ADDR, a, any_frame());
                repeat ($urandom_range(1, 3))
                    drive_beat(OP_READ, REG_OAM_DATA, 8'($urandom), any_frame());
            end
        end else if (kind < 82) begin
            drive_beat(OP_EVENT, 3'($urandom), 8'($urandom), any_frame());
            repeat ($urandom_range(1, 2))
                drive_beat(OP_READ, REG_STATUS, 8'($urandom), status_frame());
        end else if (kind < 87) begin
            // scroll bits reach the address: bit 14 and the upper wrap
            clear_toggle();
            drive_beat(OP_WRITE, REG_ADDR, 8'($urandom), any_frame());
            drive_beat(OP_WRITE, REG_SCROLL, 8'($urandom), any_frame());
            drive_beat(OP_WRITE, REG_SCROLL, 8'($urandom), any_frame());
            drive_beat(OP_WRITE, REG_ADDR, 8'($urandom), any_frame());
            repeat ($urandom_range(1, 3))
                drive_beat(OP_WRITE, REG_DATA, 8'($urandom), any_frame());
        end else begin
            repeat ($urandom_range(1, 3)) begin
                ri = 3'($urandom);
                case ($urandom_range(5))
                    0: drive_beat(OP_NONE, ri, 8'($urandom), any_frame());
                    1: drive_beat(OP_WRITE, REG_STATUS, 8'($urandom), any_frame());
                    2: begin
                        if ((ri == REG_OAM_DATA && !oam_known[cur_oam_addr]) ||
                            (ri == REG_DATA && !data_read_ok()))
                            ri = REG_CTRL_B;
                        drive_beat(OP_READ, ri, 8'($urandom), any_frame());
                    end
                    3: drive_beat(OP_WRITE, $urandom_range(1) ? REG_SCROLL : REG_ADDR,
                                  8'($urandom), any_frame());
                    4: drive_beat(OP_WRITE, REG_DATA, 8'($urandom), any_frame());
                    default: drive_beat(OP_WRITE, REG_OAM_ADDR, 8'($urandom), any_frame());
                endcase
            end
        end
    endtask

    task automatic compare_field(input string name, input logic [14:0] want_v,
                                 input logic [14:0] got_v);
        if (got_v !== want_v) begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want_v, got_v);
            error_count++;
        end
    endtask

    // result side: random stall, score each accepted beat
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        m_axis_tready <= ($urandom_range(99) >= ready_idle_pct);
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = t_result'(m_axis_tdata[60:0]);
            if (result_queue.size() == 0) begin
                $display("%0t: unexpected result beat, expected none actual %0h",
                         $time, m_axis_tdata);
                error_count++;
            end else begin
                want = result_queue.pop_front();
                compare_field("read_data", 15'(want.read_data), 15'(got.read_data));
                compare_field("nmi_enable", 15'(want.nmi_enable), 15'(got.nmi_enable));
                compare_field("vblank_suppressed", 15'(want.vblank_suppressed),
                              15'(got.vblank_suppressed));
                compare_field("a12_rise", 15'(want.a12_rise), 15'(got.a12_rise));
                compare_field("vram_addr", want.vram_addr, got.vram_addr);
                compare_field("temp_addr", want.temp_addr, got.temp_addr);
                compare_field("fine_x", 15'(want.fine_x), 15'(got.fine_x));
                compare_field("control_a", 15'(want.control_a), 15'(got.control_a));
                compare_field("control_b", 15'(want.control_b), 15'(got.control_b));
                compare_field("write_toggle", 15'(want.write_toggle),
                              15'(got.write_toggle));
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("video_unit_register_interface verification failed");
            $finish;
        end
    end

    // stimulus
    initial begin
        // directed table: extremes, every register, the special frame cycles
        directed_rows.push_back('{OP_READ, REG_CTRL_A, 8'h00, 17'd0, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, 8'h00, 8'h00, 15'h0000)});
        directed_rows.push_back('{OP_WRITE, REG_CTRL_A, 8'hFF, 17'd0, 1'b1,
            fixed_result(8'h00, 1'b1, 1'b0, 8'hFF, 8'h00, 15'h0C00)});
        directed_rows.push_back('{OP_WRITE, REG_CTRL_B, 8'hFF, 17'd0, 1'b1,
            fixed_result(8'h00, 1'b1, 1'b0, 8'hFF, 8'hFF, 15'h0C00)});
        // late status read sets suppression, drops NMI
        directed_rows.push_back('{OP_READ, REG_STATUS, 8'h00, LAST_FRAME_CYCLE, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b1, 8'hFF, 8'hFF, 15'h0C00)});
        directed_rows.push_back('{OP_EVENT, REG_CTRL_A, 8'hE0, 17'd0, 1'b1,
            fixed_result(8'h00, 1'b0, 1'b0, 8'hFF, 8'hFF, 15'h0C00)});
        directed_rows.push_back('{OP_READ, REG_STATUS, 8'h00, 17'd1, 1'b1,
            fixed_result(8'hE0, 1'b0, 1'b0, 8'hFF, 8'hFF, 15'h0C00)});
        directed_rows.push_back('{OP_WRITE, REG_CTRL_A, 8'h80, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_READ, REG_STATUS, 8'h00, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_STATUS, 8'h55, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_NONE, REG_DATA, 8'hFF, LAST_FRAME_CYCLE, 1'b0, '0});
        // sprite address wraps after the last entry
        directed_rows.push_back('{OP_WRITE, REG_OAM_ADDR, 8'hFF, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_OAM_DATA, 8'hA5, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_OAM_ADDR, 8'hFF, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_READ, REG_OAM_DATA, 8'h00, 17'd0, 1'b0, '0});
        // palette entry 0 fans out to its mirrors
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'h3F, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'h00, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_DATA, 8'h11, 17'd0, 1'b0, '0});
        // address 0x7FFF through the scroll bits, then a wrapping increment of 32
        directed_rows.push_back('{OP_WRITE, REG_CTRL_A, 8'h04, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'h3F, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_SCROLL, 8'hFF, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_SCROLL, 8'hFF, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'hFF, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_DATA, 8'h5A, 17'd0, 1'b0, '0});
        // plain video write, then a buffered read of it
        directed_rows.push_back('{OP_WRITE, REG_DATA, 8'hC3, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'h00, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_WRITE, REG_ADDR, 8'h1F, 17'd0, 1'b0, '0});
        directed_rows.push_back('{OP_READ, REG_DATA, 8'h00, 17'd0, 1'b0, '0});

        send_idle_pct = 33;
        ready_idle_pct <= 78;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[k])
            drive_beat(directed_rows[k].op, directed_rows[k].ri, directed_rows[k].d,
                       directed_rows[k].fc, directed_rows[k].has_fixed,
                       directed_rows[k].fixed);

        // random traffic in three stall mixes
        for (int phase = 0; phase < 3; phase++) begin
            int phase_end;
            case (phase)
                0: begin
                    send_idle_pct = 33;
                    ready_idle_pct <= 78;
                end
                1: begin
                    send_idle_pct = 78;
                    ready_idle_pct <= 33;
                end
                default: begin
                    send_idle_pct = 0;
                    ready_idle_pct <= 0;
                end
            endcase
            phase_end = beats_sent + PHASE_BEATS;
            while (beats_sent < phase_end) run_random_sequence();
        end

        s_axis_tvalid <= 1'b0;
        while (result_queue.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (error_count == 0) begin
            $display("video_unit_register_interface verification clean");
        end else begin
            $display("video_unit_register_interface verification failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
